[rtl/etpc_pkg.sv]
// Shared types and codes for the event/timing performance counter.
package etpc_pkg;

  // Counter mode register codes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_EVENT    = 2'd0;
  localparam mode_t MODE_ELAPSED  = 2'd1;
  localparam mode_t MODE_INTERVAL = 2'd2;

  // Commands carried by each input item
  typedef enum logic [2:0] {
    CMD_COUNT  = 3'd0,
    CMD_BEGIN  = 3'd1,
    CMD_END    = 3'd2,
    CMD_SETEL  = 3'd3,
    CMD_SETCNT = 3'd4,
    CMD_CANCEL = 3'd5,
    CMD_RESET  = 3'd6,
    CMD_READ   = 3'd7
  } cmd_t;

  // Input item
  typedef struct packed {
    cmd_t        command;
    logic [63:0] now_us;
    logic [63:0] value;
  } item_t;

  // Result item
  typedef struct packed {
    logic [63:0] events;
    logic [63:0] total_or_span;
    logic [31:0] least_us;
    logic [31:0] most_us;
    logic [63:0] gap_us;
  } result_t;

  // Counter state
  typedef struct packed {
    logic [63:0] event_total;
    logic [63:0] start_stamp;
    logic [63:0] time_sum;
    logic [31:0] min_seen;
    logic [31:0] max_seen;
    logic [63:0] first_stamp;
    logic [63:0] last_stamp;
  } state_t;

endpackage

[rtl/etpc_chan_if.sv]
// Valid/ready channel interface with a typed payload.
interface etpc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/etpc_update.sv]
// Next-state and result logic for one item of the performance counter.
module etpc_update
  import etpc_pkg::*;
(
  input  mode_t   mode,
  input  item_t   item,
  input  state_t  cur,
  output state_t  nxt,
  output result_t res
);

  logic [63:0] dur;
  logic [31:0] dur_low;
  logic        dur_ok;
  logic [63:0] gap;
  logic [31:0] gap_low;
  logic [63:0] gap_out;

  // Pick the duration: measured for end, injected for set elapsed
  assign dur     = (item.command == CMD_END) ? (item.now_us - cur.start_stamp) : item.value;
  assign dur_low = dur[31:0];
  assign dur_ok  = !dur[63];

  // Gap since the last counted event
  assign gap     = item.now_us - cur.last_stamp;
  assign gap_low = gap[31:0];

  // Apply the command under the current mode
  always_comb begin
    nxt     = cur;
    gap_out = '0;
    if (item.command == CMD_RESET) begin
      nxt = '0;
    end else begin
      case (mode)
        MODE_EVENT: begin
          if (item.command == CMD_COUNT) begin
            nxt.event_total = cur.event_total + 64'd1;
          end else if (item.command == CMD_SETCNT) begin
            nxt.event_total = item.value;
          end
        end
        MODE_ELAPSED: begin
          case (item.command)
            CMD_BEGIN:  nxt.start_stamp = item.now_us;
            CMD_CANCEL: nxt.start_stamp = '0;
            CMD_END, CMD_SETEL: begin
              // End needs a latched start; negative durations are dropped
              if (dur_ok && (item.command == CMD_SETEL || cur.start_stamp != 64'd0)) begin
                nxt.event_total = cur.event_total + 64'd1;
                nxt.time_sum    = cur.time_sum + dur;
                if (cur.min_seen == 32'd0 || cur.min_seen > dur_low) begin
                  nxt.min_seen = dur_low;
                end
                if (cur.max_seen < dur_low) begin
                  nxt.max_seen = dur_low;
                end
                nxt.start_stamp = '0;
              end
            end
            default: ;
          endcase
        end
        MODE_INTERVAL: begin
          if (item.command == CMD_COUNT) begin
            if (cur.event_total == 64'd0) begin
              nxt.first_stamp = item.now_us;
            end else if (cur.event_total == 64'd1) begin
              nxt.min_seen = gap_low;
              nxt.max_seen = gap_low;
            end else begin
              if (gap_low < cur.min_seen) begin
                nxt.min_seen = gap_low;
              end
              if (gap_low > cur.max_seen) begin
                nxt.max_seen = gap_low;
              end
              gap_out = gap;
            end
            nxt.last_stamp  = item.now_us;
            nxt.event_total = cur.event_total + 64'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Build the result from the updated state
  always_comb begin
    res.events   = nxt.event_total;
    res.least_us = nxt.min_seen;
    res.most_us  = nxt.max_seen;
    res.gap_us   = gap_out;
    case (mode)
      MODE_ELAPSED:  res.total_or_span = nxt.time_sum;
      MODE_INTERVAL: res.total_or_span = nxt.last_stamp - nxt.first_stamp;
      default:       res.total_or_span = '0;
    endcase
  end

endmodule

[rtl/event_timing_perf_counter_core.sv]
// Event/timing performance counter: one counter in event, elapsed or interval mode.
// An item's result is offered after the input register and then the result register.
// Throughput: one item per cycle unless the result stalls; the state update is one pass of logic per item.
// Input and result each sit in a register; a held result does not stop intake while
// the input register is free. Reset clears the counter state and both valid flags
// and sets the mode to event counting.
module event_timing_perf_counter_core
  import etpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  etpc_chan_if.sink   item,
  etpc_chan_if.source result,
  etpc_chan_if.sink   cfg
);

  mode_t   mode;
  state_t  state;
  state_t  state_next;
  item_t   in_item;
  logic    in_valid;
  result_t res_next;
  result_t out_res;
  logic    out_valid;
  logic    fire;

  // Configuration is always taken
  assign cfg.ready = 1'b1;

  // Process the held item when the result register can take it
  assign fire       = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || fire;

  assign result.valid = out_valid;
  assign result.data  = out_res;

  etpc_update u_update (
    .mode (mode),
    .item (in_item),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Hold mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_EVENT;
    end else if (cfg.valid) begin
      mode <= cfg.data;
    end
  end

  // Advance input register, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (item.valid && item.ready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item <= item.data;
    end
    if (fire) begin
      out_res <= res_next;
    end
  end

endmodule

[dv/tb_event_timing_perf_counter_core.sv]
`timescale 1ns / 1ps
// Testbench for the event/timing performance counter core with a self-checking scoreboard.
module tb_event_timing_perf_counter_core
  import etpc_pkg::*;
();

  // Mode code 3 is not used by the block; it should ignore all but reset
  localparam mode_t MODE_UNUSED = 2'd3;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

  // Mirror the counter state and hold the readings it must produce, oldest first
  class counter_scoreboard;
    mode_t       mode;
    state_t      st;
    result_t     readings_due[$];
    int unsigned err_count;

    function new();
      mode = MODE_EVENT;
      st = '0;
      err_count = 0;
    endfunction

    // Fold one duration into the elapsed totals; drop it when it reads negative
    function void take_duration(logic [63:0] d);
      logic [31:0] low;
      low = d[31:0];
      if (d[63]) return;
      st.event_total = st.event_total + 64'd1;
      st.time_sum = st.time_sum + d;
      if (st.min_seen == 32'd0 || st.min_seen > low) st.min_seen = low;
      if (st.max_seen < low) st.max_seen = low;
      st.start_stamp = 64'd0;
    endfunction

    // Advance the counter state by one item and build the reading it gives
    function result_t predict_reading(item_t it);
      result_t     r;
      logic [63:0] gap;
      r = '0;
      gap = it.now_us - st.last_stamp;
      if (it.command == CMD_RESET) begin
        st = '0;
      end else begin
        case (mode)
          MODE_EVENT: begin
            if (it.command == CMD_COUNT) st.event_total = st.event_total + 64'd1;
            else if (it.command == CMD_SETCNT) st.event_total = it.value;
          end
          MODE_ELAPSED: begin
            case (it.command)
              CMD_BEGIN: st.start_stamp = it.now_us;
              CMD_END: begin
                if (st.start_stamp != 64'd0) take_duration(it.now_us - st.start_stamp);
              end
              CMD_SETEL: take_duration(it.value);
              CMD_CANCEL: st.start_stamp = 64'd0;
              default: ;
            endcase
          end
          MODE_INTERVAL: begin
            if (it.command == CMD_COUNT) begin
              if (st.event_total == 64'd0) begin
                st.first_stamp = it.now_us;
              end else if (st.event_total == 64'd1) begin
                st.min_seen = gap[31:0];
                st.max_seen = gap[31:0];
              end else begin
                if (gap[31:0] < st.min_seen) st.min_seen = gap[31:0];
                if (gap[31:0] > st.max_seen) st.max_seen = gap[31:0];
                r.gap_us = gap;
              end
              st.last_stamp = it.now_us;
              st.event_total = st.event_total + 64'd1;
            end
          end
          default: ;
        endcase
      end
      r.events = st.event_total;
      if (mode == MODE_ELAPSED) r.total_or_span = st.time_sum;
      else if (mode == MODE_INTERVAL) r.total_or_span = st.last_stamp - st.first_stamp;
      r.least_us = st.min_seen;
      r.most_us = st.max_seen;
      return r;
    endfunction

    function void note_item(item_t it);
      readings_due.push_back(predict_reading(it));
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
      err_count++;
    endtask

    // Compare one result transfer against the oldest pending reading
    task check_reading(result_t got);
      result_t want;
      if (readings_due.size() == 0) begin
        report_mismatch("result with nothing pending", got.events, 64'd0);
        return;
      end
      want = readings_due.pop_front();
      if (got.events !== want.events) report_mismatch("events", got.events, want.events);
      if (got.total_or_span !== want.total_or_span)
        report_mismatch("total_or_span", got.total_or_span, want.total_or_span);
      if (got.least_us !== want.least_us)
        report_mismatch("least_us", {32'd0, got.least_us}, {32'd0, want.least_us});
      if (got.most_us !== want.most_us)
        report_mismatch("most_us", {32'd0, got.most_us}, {32'd0, want.most_us});
      if (got.gap_us !== want.gap_us) report_mismatch("gap_us", got.gap_us, want.gap_us);
    endtask
  endclass

  logic        clk;
  logic        rst;
  bit          idle_on;
  logic [63:0] clock_us;
  mode_t       phase_modes [12] = '{MODE_ELAPSED, MODE_INTERVAL, MODE_EVENT, MODE_INTERVAL,
                                    MODE_ELAPSED, MODE_UNUSED, MODE_EVENT, MODE_ELAPSED,
                                    MODE_INTERVAL, MODE_INTERVAL, MODE_ELAPSED, MODE_EVENT};

  counter_scoreboard sb = new();

  etpc_chan_if #(.payload_t(item_t))   item_ch ();
  etpc_chan_if #(.payload_t(result_t)) result_ch ();
  etpc_chan_if #(.payload_t(mode_t))   cfg_ch ();

  event_timing_perf_counter_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check each result transfer, then pick the next ready with random stalls
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) sb.check_reading(result_ch.data);
    result_ch.ready <= !(idle_on && $urandom_range(99) < 10);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t make_item(cmd_t c, logic [63:0] now, logic [63:0] val);
    item_t it;
    it.command = c;
    it.now_us = now;
    it.value = val;
    return it;
  endfunction

  // Build one random item shaped for the given mode
  function automatic item_t gen_item(mode_t m);
    int unsigned pick;
    int unsigned step;
    logic [63:0] now;
    logic [63:0] val;
    cmd_t        c;
    step = $urandom_range(99);
    if (step < 90) clock_us = clock_us + 64'($urandom_range(1, 5000));
    else if (step < 97) clock_us = clock_us + {30'd0, 2'($urandom_range(3)), $urandom};
    else clock_us = rand64();
    now = ($urandom_range(99) < 4) ? rand64() : clock_us;
    val = rand64();
    c = cmd_t'($urandom_range(7));
    pick = $urandom_range(99);
    case (m)
      MODE_ELAPSED: begin
        if (pick < 35) c = CMD_BEGIN;
        else if (pick < 70) c = CMD_END;
        else if (pick < 82) begin
          c = CMD_SETEL;
          step = $urandom_range(99);
          if (step < 50) val = 64'($urandom_range(0, 100000));
          else if (step < 75) val = val & ~TOP_BIT;
          else if (step < 85) val = TOP_BIT | 64'($urandom_range(0, 100));
        end else if (pick < 87) c = CMD_CANCEL;
        else if (pick < 89) c = CMD_RESET;
      end
      MODE_INTERVAL: begin
        if (pick < 80) c = CMD_COUNT;
        else if (pick < 83) c = CMD_RESET;
      end
      MODE_EVENT: begin
        if (pick < 60) c = CMD_COUNT;
        else if (pick < 75) begin
          c = CMD_SETCNT;
          step = $urandom_range(99);
          if (step < 30) val = ALL_ONES - 64'($urandom_range(0, 3));
          else if (step < 60) val = 64'($urandom_range(0, 20));
        end else if (pick < 78) c = CMD_RESET;
      end
      default: ;
    endcase
    return make_item(c, now, val);
  endfunction

  // Offer one item, idling now and then, and hold it until the transfer
  task automatic send_item(item_t it);
    if (idle_on && $urandom_range(99) < 10) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    sb.note_item(it);
  endtask

  // Stop sending and wait for every pending reading to come back
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.readings_due.size() != 0);
  endtask

  // Write the mode register while the block is idle
  task automatic set_mode(mode_t m);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= m;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.mode = m;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    idle_on = 1'b1;
    clock_us = 64'd1000;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= MODE_EVENT;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Event mode after reset: count, load all ones, wrap, read, ignored begin
    send_item(make_item(CMD_COUNT, 64'd5, ALL_ONES));
    send_item(make_item(CMD_SETCNT, 64'd0, ALL_ONES));
    send_item(make_item(CMD_COUNT, ALL_ONES, 64'd0));
    send_item(make_item(CMD_READ, 64'd7, 64'd9));
    send_item(make_item(CMD_BEGIN, 64'd50, 64'd1));

    // Elapsed mode: a pair, a negative duration, a wide one, an end before begin,
    // cancel, end while not started, begin at time zero, a zero duration
    set_mode(MODE_ELAPSED);
    send_item(make_item(CMD_BEGIN, 64'd100, 64'd0));
    send_item(make_item(CMD_END, 64'd350, 64'd0));
    send_item(make_item(CMD_SETEL, 64'd0, TOP_BIT));
    send_item(make_item(CMD_SETEL, 64'd0, 64'h1_0000_0005));
    send_item(make_item(CMD_BEGIN, 64'd1000, 64'd0));
    send_item(make_item(CMD_END, 64'd500, 64'd0));
    send_item(make_item(CMD_CANCEL, 64'd600, 64'd0));
    send_item(make_item(CMD_END, 64'd700, 64'd0));
    send_item(make_item(CMD_BEGIN, 64'd0, 64'd0));
    send_item(make_item(CMD_END, 64'd900, 64'd0));
    send_item(make_item(CMD_SETEL, 64'd0, 64'd0));

    // Interval mode from clear: first, second, a backward gap, a huge gap
    set_mode(MODE_INTERVAL);
    send_item(make_item(CMD_RESET, 64'd0, 64'd0));
    send_item(make_item(CMD_COUNT, 64'd10, 64'd0));
    send_item(make_item(CMD_COUNT, 64'd30, 64'd0));
    send_item(make_item(CMD_COUNT, 64'd25, 64'd0));
    send_item(make_item(CMD_COUNT, ALL_ONES, 64'd0));

    // Unused mode ignores all but reset
    set_mode(MODE_UNUSED);
    send_item(make_item(CMD_COUNT, 64'd40, 64'd3));
    send_item(make_item(CMD_SETCNT, 64'd41, 64'd3));
    send_item(make_item(CMD_RESET, 64'd42, 64'd3));

    // Random phases, one mode each; a long stretch runs without idling
    foreach (phase_modes[p]) begin
      idle_on = !(p == 3 || p == 4);
      set_mode(phase_modes[p]);
      for (int n = 0; n < 50; n++) begin
        if (p == 6 && n == 25) wait_drained();
        send_item(gen_item(phase_modes[p]));
      end
    end
    idle_on = 1'b1;

    // Drain, let the pipeline settle, then report
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.err_count == 0 && sb.readings_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
rtl/etpc_pkg.sv
rtl/etpc_chan_if.sv
rtl/etpc_update.sv
rtl/event_timing_perf_counter_core.sv
dv/tb_event_timing_perf_counter_core.sv
